// ===== rtl/core/sfb_pkg.sv =====
// ----------------------------------------------------------------------------
// sfb_pkg: shared types, constants and CRC helper for the frame builder
// Holds request codes, sequencer phases, config reset values and the
// byte-wise CRC16/MODBUS update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfb_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CrcW     = 16;
  localparam int unsigned ReqW     = 2;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 4;

  localparam logic [CrcW-1:0]  CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0]  CrcPoly = 16'hA001;
  localparam logic [ByteW:0]   MsgHdrLen = 9'd3;

  localparam logic [ByteW-1:0] HeaderFirstRst  = 8'd170;
  localparam logic [ByteW-1:0] HeaderSecondRst = 8'd85;
  localparam logic [ByteW-1:0] TailValueRst    = 8'd90;
  localparam logic [ByteW-1:0] MaxDataLenRst   = 8'd255;

  // Register indexes on the config port
  typedef enum logic [1:0] {
    REG_HEADER_FIRST  = 2'd0,
    REG_HEADER_SECOND = 2'd1,
    REG_TAIL_VALUE    = 2'd2,
    REG_MAX_DATA_LEN  = 2'd3
  } sfb_reg_e;

  typedef enum logic [ReqW-1:0] {
    REQ_MSG = 2'd0,
    REQ_RAW = 2'd1,
    REQ_PAY = 2'd2
  } sfb_req_e;

  typedef enum logic [3:0] {
    PH_START,
    PH_ERR,
    PH_HDR1,
    PH_HDR2,
    PH_LEN,
    PH_MT,
    PH_SN,
    PH_SQ,
    PH_DATA,
    PH_CRCL,
    PH_CRCH,
    PH_TAIL,
    PH_SKIP
  } sfb_phase_e;

  typedef struct packed {
    logic [ByteW-1:0] header_first;
    logic [ByteW-1:0] header_second;
    logic [ByteW-1:0] tail_value;
    logic [ByteW-1:0] max_data_len;
  } sfb_cfg_t;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [ByteW-1:0] msg_type;
    logic [ByteW-1:0] session_num;
    logic [ByteW-1:0] seq_num;
    logic [ByteW-1:0] length_in;
    logic [ByteW-1:0] byte_in;
  } sfb_item_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
    logic             last;
    logic             err;
  } sfb_beat_t;

  // One byte through the reflected CRC16/MODBUS register
  function automatic logic [CrcW-1:0] crc16_upd(input logic [CrcW-1:0]  crc,
                                                input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int i = 0; i < ByteW; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/serial_frame_builder_crc16_core.sv =====
// ----------------------------------------------------------------------------
// serial_frame_builder_crc16_core: length-prefixed frame builder, CRC16
// Input register, frame sequencer and output register for wire bytes.
// ----------------------------------------------------------------------------
// Path: an accepted item waits in the input register; the sequencer passes its
//   wire bytes through the output register. Throughput: one wire byte per cycle
//   while the sink does not stall. A payload byte emits itself (plus CRC and tail
//   when it closes the frame), a begin the headers and length (message type,
//   session, sequence for a message; CRC, tail if empty), a rejection one error byte.
// Reset: asynchronous, active low; clears frame state, CRC to 0xFFFF, config to defaults.
`timescale 1ns / 1ps

module serial_frame_builder_crc16_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [7:0] msg_type, [15:8] session_num, [23:16] seq_num,
  // [31:24] length_in, [39:32] byte_in
  input  logic [39:0]                  s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]                   s_axis_tuser,
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]                   m_axis_tdata,
  output logic                         m_axis_tlast,
  // [0] out_error
  output logic [0:0]                   m_axis_tuser,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfb_pkg::ApbAddrW-1:0] paddr,
  input  logic [sfb_pkg::ApbDataW-1:0] pwdata,
  output logic [sfb_pkg::ApbDataW-1:0] prdata,
  output logic                         pready
);

  sfb_pkg::sfb_cfg_t  cfg;
  sfb_pkg::sfb_item_t item_q, item_d;
  sfb_pkg::sfb_beat_t beat;
  logic               item_valid_q, item_valid_d;
  logic               in_xfer;
  logic               seq_done;
  logic               out_free;

  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_byte_q;
  logic               out_last_q;
  logic               out_err_q;

  sfb_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Take a new item when the slot is empty or its last step retires now
  assign s_axis_tready = !item_valid_q || seq_done;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_d.req_type    = s_axis_tuser;
    item_d.msg_type    = s_axis_tdata[7:0];
    item_d.session_num = s_axis_tdata[15:8];
    item_d.seq_num     = s_axis_tdata[23:16];
    item_d.length_in   = s_axis_tdata[31:24];
    item_d.byte_in     = s_axis_tdata[39:32];
  end

  always_comb begin
    if (in_xfer) begin
      item_valid_d = 1'b1;
    end else if (seq_done) begin
      item_valid_d = 1'b0;
    end else begin
      item_valid_d = item_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  // Payload register: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= item_d;
    end
  end

  // Output slot frees up when empty or when its byte is taken this cycle
  assign out_free = !out_valid_q || m_axis_tready;

  sfb_frame_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_i       (item_q),
    .item_valid_i (item_valid_q),
    .out_free_i   (out_free),
    .done_o       (seq_done),
    .beat_o       (beat)
  );

  always_comb begin
    out_valid_d = out_free ? beat.valid : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the byte while the sink stalls
  always_ff @(posedge clk_i) begin
    if (out_free && beat.valid) begin
      out_byte_q <= beat.data;
      out_last_q <= beat.last;
      out_err_q  <= beat.err;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_byte_q;
  assign m_axis_tlast    = out_last_q;
  assign m_axis_tuser[0] = out_err_q;

endmodule

// ===== rtl/core/sfb_apb_regs.sv =====
// ----------------------------------------------------------------------------
// sfb_apb_regs: configuration register file
// APB-style slave holding header, tail and length-limit bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfb_apb_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sfb_pkg::ApbAddrW-1:0]        paddr,
  input  logic [sfb_pkg::ApbDataW-1:0]        pwdata,
  output logic [sfb_pkg::ApbDataW-1:0]        prdata,
  output logic                                pready,
  output sfb_pkg::sfb_cfg_t                   cfg_o
);

  sfb_pkg::sfb_cfg_t cfg_q, cfg_d;
  sfb_pkg::sfb_reg_e sel;
  logic              wr_en;
  logic [sfb_pkg::ByteW-1:0] rd_byte;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = sfb_pkg::sfb_reg_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        sfb_pkg::REG_HEADER_FIRST:  cfg_d.header_first  = pwdata[sfb_pkg::ByteW-1:0];
        sfb_pkg::REG_HEADER_SECOND: cfg_d.header_second = pwdata[sfb_pkg::ByteW-1:0];
        sfb_pkg::REG_TAIL_VALUE:    cfg_d.tail_value    = pwdata[sfb_pkg::ByteW-1:0];
        sfb_pkg::REG_MAX_DATA_LEN:  cfg_d.max_data_len  = pwdata[sfb_pkg::ByteW-1:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      sfb_pkg::REG_HEADER_FIRST:  rd_byte = cfg_q.header_first;
      sfb_pkg::REG_HEADER_SECOND: rd_byte = cfg_q.header_second;
      sfb_pkg::REG_TAIL_VALUE:    rd_byte = cfg_q.tail_value;
      sfb_pkg::REG_MAX_DATA_LEN:  rd_byte = cfg_q.max_data_len;
      default:                    rd_byte = '0;
    endcase
  end

  assign prdata = {{(sfb_pkg::ApbDataW-sfb_pkg::ByteW){1'b0}}, rd_byte};
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first  <= sfb_pkg::HeaderFirstRst;
      cfg_q.header_second <= sfb_pkg::HeaderSecondRst;
      cfg_q.tail_value    <= sfb_pkg::TailValueRst;
      cfg_q.max_data_len  <= sfb_pkg::MaxDataLenRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/core/sfb_frame_seq.sv =====
// ----------------------------------------------------------------------------
// sfb_frame_seq: frame sequencer
// Walks the wire bytes caused by the held item, one per step, and keeps
// the CRC, byte count and frame flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfb_frame_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfb_pkg::sfb_cfg_t    cfg_i,
  input  sfb_pkg::sfb_item_t   item_i,
  input  logic                 item_valid_i,
  input  logic                 out_free_i,
  output logic                 done_o,
  output sfb_pkg::sfb_beat_t   beat_o
);

  sfb_pkg::sfb_phase_e ph_q, cur_ph, first_ph, nxt_ph;
  sfb_pkg::sfb_req_e   req;

  logic [sfb_pkg::CrcW-1:0]  crc_q, crc_d;
  logic [sfb_pkg::ByteW-1:0] bl_q, bl_d;
  logic                      fo_q, fo_d;
  logic                      dr_q, dr_d;

  logic [sfb_pkg::ByteW:0]   total;
  logic                      too_long;
  logic                      is_msg;
  logic                      len_zero;
  logic                      emit_req;
  logic                      last_step;
  logic                      advance;
  logic [sfb_pkg::ByteW-1:0] ob;
  logic                      olast, oerr;

  assign req      = sfb_pkg::sfb_req_e'(item_i.req_type);
  assign is_msg   = (req == sfb_pkg::REQ_MSG);
  assign len_zero = (item_i.length_in == '0);
  assign total    = is_msg ? ({1'b0, item_i.length_in} + sfb_pkg::MsgHdrLen)
                           : {1'b0, item_i.length_in};
  assign too_long = total > {1'b0, cfg_i.max_data_len};

  always_comb begin
    unique case (req)
      sfb_pkg::REQ_MSG,
      sfb_pkg::REQ_RAW: first_ph = too_long ? sfb_pkg::PH_ERR : sfb_pkg::PH_HDR1;
      sfb_pkg::REQ_PAY: first_ph = fo_q ? sfb_pkg::PH_DATA : sfb_pkg::PH_SKIP;
      default:          first_ph = sfb_pkg::PH_SKIP;
    endcase
  end

  assign cur_ph = (ph_q == sfb_pkg::PH_START) ? first_ph : ph_q;

  always_comb begin
    emit_req  = 1'b0;
    ob        = '0;
    olast     = 1'b0;
    oerr      = 1'b0;
    last_step = 1'b0;
    nxt_ph    = sfb_pkg::PH_START;
    crc_d     = crc_q;
    bl_d      = bl_q;
    fo_d      = fo_q;
    dr_d      = dr_q;
    unique case (cur_ph)
      sfb_pkg::PH_ERR: begin
        emit_req  = 1'b1;
        olast     = 1'b1;
        oerr      = 1'b1;
        fo_d      = 1'b0;
        dr_d      = !len_zero;
        bl_d      = item_i.length_in;
        crc_d     = sfb_pkg::CrcInit;
        last_step = 1'b1;
      end
      sfb_pkg::PH_HDR1: begin
        emit_req = 1'b1;
        ob       = cfg_i.header_first;
        crc_d    = sfb_pkg::crc16_upd(sfb_pkg::CrcInit, ob);
        fo_d     = 1'b0;
        dr_d     = 1'b0;
        nxt_ph   = sfb_pkg::PH_HDR2;
      end
      sfb_pkg::PH_HDR2: begin
        emit_req = 1'b1;
        ob       = cfg_i.header_second;
        crc_d    = sfb_pkg::crc16_upd(crc_q, ob);
        nxt_ph   = sfb_pkg::PH_LEN;
      end
      sfb_pkg::PH_LEN: begin
        emit_req = 1'b1;
        ob       = total[sfb_pkg::ByteW-1:0];
        crc_d    = sfb_pkg::crc16_upd(crc_q, ob);
        bl_d     = item_i.length_in;
        if (is_msg) begin
          nxt_ph = sfb_pkg::PH_MT;
        end else if (len_zero) begin
          nxt_ph = sfb_pkg::PH_CRCL;
        end else begin
          fo_d      = 1'b1;
          last_step = 1'b1;
        end
      end
      sfb_pkg::PH_MT: begin
        emit_req = 1'b1;
        ob       = item_i.msg_type;
        crc_d    = sfb_pkg::crc16_upd(crc_q, ob);
        nxt_ph   = sfb_pkg::PH_SN;
      end
      sfb_pkg::PH_SN: begin
        emit_req = 1'b1;
        ob       = item_i.session_num;
        crc_d    = sfb_pkg::crc16_upd(crc_q, ob);
        nxt_ph   = sfb_pkg::PH_SQ;
      end
      sfb_pkg::PH_SQ: begin
        emit_req = 1'b1;
        ob       = item_i.seq_num;
        crc_d    = sfb_pkg::crc16_upd(crc_q, ob);
        if (len_zero) begin
          nxt_ph = sfb_pkg::PH_CRCL;
        end else begin
          fo_d      = 1'b1;
          last_step = 1'b1;
        end
      end
      sfb_pkg::PH_DATA: begin
        emit_req = 1'b1;
        ob       = item_i.byte_in;
        crc_d    = sfb_pkg::crc16_upd(crc_q, ob);
        bl_d     = bl_q - 8'd1;
        if (bl_q == 8'd1) begin
          nxt_ph = sfb_pkg::PH_CRCL;
        end else begin
          last_step = 1'b1;
        end
      end
      sfb_pkg::PH_CRCL: begin
        emit_req = 1'b1;
        ob       = crc_q[sfb_pkg::ByteW-1:0];
        nxt_ph   = sfb_pkg::PH_CRCH;
      end
      sfb_pkg::PH_CRCH: begin
        emit_req = 1'b1;
        ob       = crc_q[sfb_pkg::CrcW-1:sfb_pkg::ByteW];
        nxt_ph   = sfb_pkg::PH_TAIL;
      end
      sfb_pkg::PH_TAIL: begin
        emit_req  = 1'b1;
        ob        = cfg_i.tail_value;
        olast     = 1'b1;
        fo_d      = 1'b0;
        crc_d     = sfb_pkg::CrcInit;
        last_step = 1'b1;
      end
      sfb_pkg::PH_SKIP: begin
        // count down the bytes of a rejected frame
        if (req == sfb_pkg::REQ_PAY && !fo_q && dr_q) begin
          bl_d = bl_q - 8'd1;
          if (bl_q == 8'd1) begin
            dr_d = 1'b0;
          end
        end
        last_step = 1'b1;
      end
      default: begin
        last_step = 1'b1;
      end
    endcase
  end

  assign advance = item_valid_i && (!emit_req || out_free_i);
  assign done_o  = advance && last_step;

  assign beat_o.valid = advance && emit_req;
  assign beat_o.data  = ob;
  assign beat_o.last  = olast;
  assign beat_o.err   = oerr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= sfb_pkg::PH_START;
      crc_q <= sfb_pkg::CrcInit;
      bl_q  <= '0;
      fo_q  <= 1'b0;
      dr_q  <= 1'b0;
    end else if (advance) begin
      ph_q  <= last_step ? sfb_pkg::PH_START : nxt_ph;
      crc_q <= crc_d;
      bl_q  <= bl_d;
      fo_q  <= fo_d;
      dr_q  <= dr_d;
    end
  end

`ifndef SYNTH
  a_open_xor_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fo_q && dr_q))
    else $error("frame open and dropping at once");

  a_drop_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dr_q |-> (bl_q != '0))
    else $error("dropping with no bytes left");

  a_open_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fo_q && ph_q == sfb_pkg::PH_START) |-> (bl_q != '0))
    else $error("open frame between items with no bytes left");

  a_mid_item_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q != sfb_pkg::PH_START) |-> item_valid_i)
    else $error("sequence in progress without a held item");
`endif

endmodule

// ===== verif/sfb_frame_checker.sv =====
// ----------------------------------------------------------------------------
// sfb_frame_checker: wire-byte predictor and scoreboard for the frame builder
// Tracks config writes and accepted request transfers, predicts every wire
// byte of each frame, and compares each output transfer with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfb_frame_checker
  import sfb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [39:0]         s_tdata_i,
  input  logic [1:0]          s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [7:0]          m_tdata_i,
  input  logic                m_tlast_i,
  input  logic [0:0]          m_tuser_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [ApbAddrW-1:0] paddr_i,
  input  logic [ApbDataW-1:0] pwdata_i,
  input  logic                pready_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         pending_bytes_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } wire_byte_t;

  wire_byte_t      wire_bytes_q[$];
  wire_byte_t      got_byte;
  wire_byte_t      want_byte;
  sfb_cfg_t        cfg;
  logic [CrcW-1:0] crc_run;
  logic [7:0]      bytes_left;
  logic            frame_open;
  logic            dropping;

  task automatic put_byte(input logic [7:0] b, input logic last, input logic err);
    wire_byte_t beat;
    beat.data = b;
    beat.last = last;
    beat.err  = err;
    wire_bytes_q.push_back(beat);
  endtask

  // Bit-serial reflected CRC, then emit the byte itself
  task automatic crc_byte(input logic [7:0] b);
    logic fb;
    for (int k = 0; k < 8; k++) begin
      fb      = crc_run[0] ^ b[k];
      crc_run = {1'b0, crc_run[CrcW-1:1]} ^ (fb ? CrcPoly : '0);
    end
    put_byte(b, 1'b0, 1'b0);
  endtask

  task automatic close_frame();
    put_byte(crc_run[7:0], 1'b0, 1'b0);
    put_byte(crc_run[15:8], 1'b0, 1'b0);
    put_byte(cfg.tail_value, 1'b1, 1'b0);
    frame_open = 1'b0;
    crc_run    = CrcInit;
  endtask

  task automatic build_frame_bytes(input logic [1:0] req, input logic [39:0] data);
    logic [8:0] total;
    logic [7:0] len;
    len = data[31:24];
    case (req)
      REQ_MSG, REQ_RAW: begin
        total      = (req == REQ_MSG) ? {1'b0, len} + MsgHdrLen : {1'b0, len};
        frame_open = 1'b0;
        dropping   = 1'b0;
        crc_run    = CrcInit;
        if (total > {1'b0, cfg.max_data_len}) begin
          bytes_left = len;
          dropping   = (len != 8'd0);
          put_byte(8'd0, 1'b1, 1'b1);
        end else begin
          crc_byte(cfg.header_first);
          crc_byte(cfg.header_second);
          crc_byte(total[7:0]);
          if (req == REQ_MSG) begin
            crc_byte(data[7:0]);
            crc_byte(data[15:8]);
            crc_byte(data[23:16]);
          end
          bytes_left = len;
          frame_open = 1'b1;
          if (len == 8'd0) close_frame();
        end
      end
      REQ_PAY: begin
        if (frame_open) begin
          crc_byte(data[39:32]);
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 8'd0) close_frame();
        end else if (dropping) begin
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 8'd0) dropping = 1'b0;
        end
      end
      default: ;  // unused selector: no bytes, no state change
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wire_bytes_q.delete();
      cfg.header_first  = HeaderFirstRst;
      cfg.header_second = HeaderSecondRst;
      cfg.tail_value    = TailValueRst;
      cfg.max_data_len  = MaxDataLenRst;
      crc_run           = CrcInit;
      bytes_left        = 8'd0;
      frame_open        = 1'b0;
      dropping          = 1'b0;
      mismatch_count_o  = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (sfb_reg_e'(paddr_i[3:2]))
          REG_HEADER_FIRST:  cfg.header_first  = pwdata_i[7:0];
          REG_HEADER_SECOND: cfg.header_second = pwdata_i[7:0];
          REG_TAIL_VALUE:    cfg.tail_value    = pwdata_i[7:0];
          REG_MAX_DATA_LEN:  cfg.max_data_len  = pwdata_i[7:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) build_frame_bytes(s_tuser_i, s_tdata_i);
      if (m_tvalid_i && m_tready_i) begin
        got_byte.data = m_tdata_i;
        got_byte.last = m_tlast_i;
        got_byte.err  = m_tuser_i[0];
        if (wire_bytes_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%0t: unexpected byte %02h last %b err %b", $realtime,
                     got_byte.data, got_byte.last, got_byte.err);
        end else begin
          want_byte = wire_bytes_q.pop_front();
          if (got_byte.data !== want_byte.data || got_byte.last !== want_byte.last ||
              got_byte.err !== want_byte.err) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10)
              $display("%0t: byte mismatch exp %02h/%b/%b got %02h/%b/%b", $realtime,
                       want_byte.data, want_byte.last, want_byte.err,
                       got_byte.data, got_byte.last, got_byte.err);
          end
        end
      end
    end
    pending_bytes_o = wire_bytes_q.size();
  end

endmodule

// ===== verif/serial_frame_builder_crc16_core_tb.sv =====
// ----------------------------------------------------------------------------
// serial_frame_builder_crc16_core_tb: stimulus and verdict for the builder
// Drives directed and random request streams under several header, tail and
// length-limit settings, with random stalls on both sides; the checker
// predicts and compares every wire byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_frame_builder_crc16_core_tb;
  import sfb_pkg::*;

  localparam logic [1:0]  ReqUnused   = 2'd3;   // selector the block must ignore
  localparam int unsigned DrainCycles = 16;     // covers the in-flight dropped bytes
  localparam int unsigned IdleLimit   = 2000;   // cycles without any transfer

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [39:0]         s_axis_tdata  = '0;
  logic [1:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tlast;
  logic [0:0]          m_axis_tuser;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ApbAddrW-1:0] paddr         = '0;
  logic [ApbDataW-1:0] pwdata        = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int unsigned mismatch_count;
  int unsigned pending_bytes;
  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 45;
  int unsigned item_count    = 0;
  int unsigned stall_cycles  = 0;
  logic [7:0]  cfg_max       = MaxDataLenRst;   // local copy of the length limit

  always #4 clk_i = ~clk_i;

  serial_frame_builder_crc16_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  sfb_frame_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .s_tuser_i        (s_axis_tuser),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .m_tlast_i        (m_axis_tlast),
    .m_tuser_i        (m_axis_tuser),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .pready_i         (pready),
    .mismatch_count_o (mismatch_count),
    .pending_bytes_o  (pending_bytes)
  );

  // Receiver: drop tready at random for the configured share of cycles
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: a run that stops moving transfers for too long has hung
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= IdleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // One request transfer: idle at random first, then hold valid until taken.
  // Called right after a rising edge, so every drive lands as one NBA per edge.
  task automatic xfer(input logic [1:0] req, input logic [39:0] data, input bit counted);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    if (counted) item_count++;
  endtask

  // tdata: [7:0] msg_type, [15:8] session, [23:16] seq, [31:24] length, [39:32] byte
  task automatic send_begin(input logic [1:0] req, input logic [7:0] mt,
                            input logic [7:0] sn, input logic [7:0] sq,
                            input logic [7:0] len);
    xfer(req, {8'($urandom), len, sq, sn, mt}, 1'b1);
  endtask

  task automatic send_pay(input logic [7:0] b, input bit counted);
    xfer(REQ_PAY, {b, 32'($urandom)}, counted);
  endtask

  // Hold off the sender until every predicted byte has come out
  task automatic wait_drained(input int unsigned extra);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_bytes != 0);
    @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Setup, access, then a quiet phase with the bus released so back-to-back writes never
  // drive the bus twice at one edge
  task automatic cfg_write(input sfb_reg_e idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'({idx, 2'b00});
    pwdata  <= {{(ApbDataW-8){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reconfigure only once the block is idle, dropped bytes included
  task automatic apply_cfg(input logic [7:0] hf, input logic [7:0] hs,
                           input logic [7:0] tail, input logic [7:0] max_len);
    wait_drained(DrainCycles);
    cfg_write(REG_HEADER_FIRST, hf);
    cfg_write(REG_HEADER_SECOND, hs);
    cfg_write(REG_TAIL_VALUE, tail);
    cfg_write(REG_MAX_DATA_LEN, max_len);
    cfg_max = max_len;
  endtask

  // Mostly complete frames with random content; some noise, rejected lengths,
  // abandoned drops and truncated frames that the next begin cuts off.
  task automatic random_frame();
    int unsigned pick;
    int unsigned hdr;
    int unsigned len;
    int unsigned nsend;
    int          room;
    sfb_req_e    req;
    pick = $urandom_range(99);
    if (pick < 6) begin
      send_pay(8'($urandom), 1'b0);
    end else if (pick < 10) begin
      xfer(ReqUnused, {8'($urandom), 32'($urandom)}, 1'b0);
    end else begin
      req  = $urandom_range(1) ? REQ_MSG : REQ_RAW;
      hdr  = (req == REQ_MSG) ? 3 : 0;
      room = int'(cfg_max) - int'(hdr);
      if (room < 0 || $urandom_range(9) == 0) begin
        len = $urandom_range(255);
      end else if ($urandom_range(9) == 0) begin
        len = $urandom_range(room < 40 ? room : 40);
      end else begin
        len = $urandom_range(room < 6 ? room : 6);
      end
      send_begin(req, 8'($urandom), 8'($urandom), 8'($urandom), 8'(len));
      nsend = len;
      // Cut long frames short, accepted or rejected alike, and some others at random
      if (len > 40) begin
        nsend = $urandom_range(4);
      end else if ($urandom_range(9) == 0) begin
        nsend = $urandom_range(len);
      end
      repeat (nsend) send_pay(8'($urandom), 1'b1);
    end
  endtask

  initial begin
    int unsigned phase_end;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: default settings written explicitly
    apply_cfg(HeaderFirstRst, HeaderSecondRst, TailValueRst, MaxDataLenRst);
    send_begin(REQ_MSG, 8'hFF, 8'h00, 8'h5A, 8'd2);
    send_pay(8'hFF, 1'b1);
    send_pay(8'h00, 1'b1);
    send_begin(REQ_RAW, 8'h00, 8'h00, 8'h00, 8'd0);    // empty raw frame
    send_begin(REQ_MSG, 8'hA5, 8'h3C, 8'hC3, 8'd0);    // header-only message
    send_pay(8'h77, 1'b0);                             // stray byte, no frame open
    xfer(ReqUnused, {40{1'b1}}, 1'b0);                 // unused selector
    send_begin(REQ_RAW, 8'h00, 8'h00, 8'h00, 8'd3);
    send_pay(8'h12, 1'b1);
    send_begin(REQ_MSG, 8'h01, 8'h02, 8'h03, 8'd1);    // abandon the raw frame
    send_pay(8'h34, 1'b1);
    send_begin(REQ_MSG, 8'h11, 8'h22, 8'h33, 8'hFF);   // too long once header added
    send_pay(8'h56, 1'b1);                             // dropped
    send_begin(REQ_RAW, 8'h00, 8'h00, 8'h00, 8'hFF);   // largest raw, cut off below
    send_pay(8'h9A, 1'b1);
    send_begin(REQ_MSG, 8'h44, 8'h55, 8'h66, 8'd252);  // exactly at the limit
    send_pay(8'hBC, 1'b1);

    // Tight limit: reject, drop the announced bytes, then a stray byte
    apply_cfg(8'h00, 8'hFF, 8'h00, 8'd5);
    send_begin(REQ_MSG, 8'hFF, 8'hFF, 8'hFF, 8'd3);
    send_pay(8'h01, 1'b1);
    send_pay(8'h02, 1'b1);
    send_pay(8'h03, 1'b1);
    send_pay(8'h04, 1'b0);
    send_begin(REQ_MSG, 8'h00, 8'h00, 8'h00, 8'd2);    // total equals the limit
    send_pay(8'hDE, 1'b1);
    send_pay(8'hAD, 1'b1);

    // Zero limit: only an empty raw frame fits
    apply_cfg(8'hFF, 8'h00, 8'hFF, 8'd0);
    send_begin(REQ_RAW, 8'h00, 8'h00, 8'h00, 8'd0);
    send_begin(REQ_MSG, 8'h00, 8'h00, 8'h00, 8'd0);
    send_pay(8'hEE, 1'b0);

    // Random: sender 19/receiver 45, then swapped, then no idling
    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 19 : (p < 4) ? 45 : 0;
      recv_idle_pct = (p < 2) ? 45 : (p < 4) ? 19 : 0;
      case (p)
        0: apply_cfg(8'($urandom), 8'($urandom), 8'($urandom), 8'd255);
        1: apply_cfg(8'h00, 8'hFF, 8'h00, 8'($urandom_range(3, 12)));
        2: apply_cfg(8'hFF, 8'h00, 8'hFF, 8'd0);
        3: apply_cfg(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(4, 40)));
        4: apply_cfg(8'($urandom), 8'($urandom), 8'($urandom), 8'd255);
        default: apply_cfg(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      phase_end = item_count + 10;
      while (item_count < phase_end) begin
        random_frame();
        if ($urandom_range(7) == 0) wait_drained(0);
      end
    end

    // Let the last frame and any dropped tail settle, then decide
    wait_drained(DrainCycles);
    if (mismatch_count == 0 && pending_bytes == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sfb_pkg.sv
rtl/core/sfb_apb_regs.sv
rtl/core/sfb_frame_seq.sv
rtl/core/serial_frame_builder_crc16_core.sv
verif/sfb_frame_checker.sv
verif/serial_frame_builder_crc16_core_tb.sv
